// File: rtl/transformed_mesh_aabb_defines.svh
// Assertion macros for the transformed mesh bounding box block.
// Used by files that check their own logic; depends on clk and rst_n in scope.
`ifndef TRANSFORMED_MESH_AABB_DEFINES_SVH
`define TRANSFORMED_MESH_AABB_DEFINES_SVH

// same-cycle implication, gated by reset
`define TMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transformed_mesh_aabb: check failed");

// next-cycle implication, gated by reset
`define TMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transformed_mesh_aabb: check failed");

`endif

// File: rtl/tma_pkg.sv
// Shared types and constants for the transformed mesh bounding box block.
// No dependencies.
package tma_pkg;

  localparam int TMA_COORD_BITS = 32;   // default bound width
  localparam int VAL_W          = 32;   // input coordinate / entry width
  localparam int ROT_W          = 16;   // Q1.14 matrix entry
  localparam int OUT_W          = 32;   // result field width
  localparam int PROD_W         = ROT_W + VAL_W;   // one exact product
  localparam int SUM_W          = PROD_W + 2;      // three products
  localparam int FRAC_DROP      = 14;              // Q16.30 -> Q16.16
  localparam int RND_W          = SUM_W - FRAC_DROP;
  localparam int EXT_W          = 49;   // covers rounded sum + offset and widest bound
  localparam int QDEPTH         = 4;

  localparam logic [1:0] ROW_INVALID = 2'd3;

  typedef enum logic [0:0] {
    CMD_VERTEX = 1'b0,
    CMD_POSE   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [0:0]              op;
    logic [1:0]              row_sel;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
    logic signed [VAL_W-1:0] val_c;
    logic signed [VAL_W-1:0] offset;
    logic [0:0]              last;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] min_x;
    logic signed [OUT_W-1:0] min_y;
    logic signed [OUT_W-1:0] min_z;
    logic signed [OUT_W-1:0] max_x;
    logic signed [OUT_W-1:0] max_y;
    logic signed [OUT_W-1:0] max_z;
  } out_item_t;

  // one queued request, already classified
  typedef struct packed {
    cmd_t                    cmd;
    logic [1:0]              row;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
    logic signed [VAL_W-1:0] val_c;
    logic signed [VAL_W-1:0] offset;
    logic                    last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/transformed_mesh_aabb.sv
// channel   handshake              payload
// in        in_valid / in_ready    in_data  (in_item_t: pose row or vertex)
// out       out_valid / out_ready  out_data (out_item_t: six bounds)
//
// Sustains one request per cycle while no finished result waits. After its last
// vertex is accepted, a result passes queue, products, rounded sum, saturate and
// bound update into out reg. The bound update register is the only datapath loop.
// A waiting result holds the back pipeline; the 4-entry queue keeps in_ready up
// until it fills. Synchronous reset zeroes the pose and reopens the bounds.
`include "transformed_mesh_aabb_defines.svh"

module transformed_mesh_aabb
  import tma_pkg::*;
#(
  parameter int COORD_BITS = TMA_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_stat_t  q_stat;
  logic     q_push, q_pop;
  q_entry_t q_wr, q_rd;

  tma_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wr     (q_wr)
  );

  tma_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .stat     (q_stat)
  );

  tma_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TMA_ASSERT_IMP(a_q_no_overflow, q_push, !q_stat.full)
  `TMA_ASSERT_IMP(a_q_no_underflow, q_pop, !q_stat.empty)
  `TMA_ASSERT_IMP(a_pose_row_legal, q_push && q_wr.cmd == CMD_POSE, q_wr.row != ROW_INVALID)
  `TMA_ASSERT_NEXT(a_q_not_empty_after_push, q_push && !q_pop, !q_stat.empty)

endmodule

// File: rtl/tma_front.sv
// Front end: accepts, classifies and queues requests, dropping invalid pose rows.
// Depends on tma_pkg.
module tma_front
  import tma_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output q_entry_t q_wr
);

  logic is_pose;
  logic drop;

  assign is_pose  = (cmd_t'(in_data.op) == CMD_POSE);
  // pose with an out-of-range row has no effect, so it never enters the queue
  assign drop     = is_pose && (in_data.row_sel == ROW_INVALID);
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready && !drop;

  always_comb begin
    q_wr.cmd    = cmd_t'(in_data.op);
    q_wr.row    = in_data.row_sel;
    q_wr.val_a  = in_data.val_a;
    q_wr.val_b  = in_data.val_b;
    q_wr.val_c  = in_data.val_c;
    q_wr.offset = in_data.offset;
    // last only matters on vertices
    q_wr.last   = in_data.last[0] && !is_pose;
  end

endmodule

// File: rtl/tma_queue.sv
// Small FIFO between front and back end.
// Depends on tma_pkg.
module tma_queue
  import tma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output q_entry_t rd_entry,
  output q_stat_t  stat
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_entry_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = push ? wptr_r + PTR_W'(1) : wptr_r;
    rptr_nxt  = pop  ? rptr_r + PTR_W'(1) : rptr_r;
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

  assign rd_entry   = mem_r[rptr_r];
  assign stat.full  = (count_r == CNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// File: rtl/tma_back.sv
// Back end: pose registers, transform pipeline, bound tracking and result register.
// Depends on tma_pkg.
module tma_back
  import tma_pkg::*;
#(
  parameter int COORD_BITS = TMA_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic signed [EXT_W-1:0] SAT_HI =
    (EXT_W'(1) << (COORD_BITS - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [COORD_BITS-1:0] C_HI = COORD_BITS'(SAT_HI);
  localparam logic signed [COORD_BITS-1:0] C_LO = COORD_BITS'(SAT_LO);
  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) << (FRAC_DROP - 1);

  // pose
  logic signed [ROT_W-1:0] rot_r [3][3];
  logic signed [VAL_W-1:0] trn_r [3];

  // stage 1: products
  logic                     s1_valid_r, s1_last_r;
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [VAL_W-1:0]  s1_t_r [3];
  // stage 2: rounded sums
  logic                     s2_valid_r, s2_last_r;
  logic signed [RND_W-1:0]  rnd_r [3];
  logic signed [VAL_W-1:0]  s2_t_r [3];
  // stage 3: saturated point
  logic                         s3_valid_r, s3_last_r;
  logic signed [COORD_BITS-1:0] pt_r [3];
  // bounds and result
  logic signed [COORD_BITS-1:0] lo_r [3];
  logic signed [COORD_BITS-1:0] hi_r [3];
  logic signed [COORD_BITS-1:0] lo_nxt [3];
  logic signed [COORD_BITS-1:0] hi_nxt [3];
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  logic                         adv;
  logic                         pop_vtx;
  logic signed [VAL_W-1:0]      vtx [3];
  logic signed [SUM_W-1:0]      sum [3];
  logic signed [EXT_W-1:0]      tot [3];
  logic signed [COORD_BITS-1:0] sat [3];

  // whole pipeline holds while a finished result waits
  assign adv     = !out_valid_r || out_ready;
  assign q_pop   = adv && !q_stat.empty;
  assign pop_vtx = q_pop && (head.cmd == CMD_VERTEX);

  assign vtx[0] = head.val_a;
  assign vtx[1] = head.val_b;
  assign vtx[2] = head.val_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        trn_r[r] <= '0;
        for (int c = 0; c < 3; c++) begin
          rot_r[r][c] <= '0;
        end
      end
    end else if (q_pop && head.cmd == CMD_POSE) begin
      rot_r[head.row][0] <= head.val_a[ROT_W-1:0];
      rot_r[head.row][1] <= head.val_b[ROT_W-1:0];
      rot_r[head.row][2] <= head.val_c[ROT_W-1:0];
      trn_r[head.row]    <= head.offset;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
             + RND_BIAS;
      tot[r] = EXT_W'(rnd_r[r]) + EXT_W'(s2_t_r[r]);
      if (tot[r] > SAT_HI) begin
        sat[r] = C_HI;
      end else if (tot[r] < SAT_LO) begin
        sat[r] = C_LO;
      end else begin
        sat[r] = COORD_BITS'(tot[r]);
      end
      lo_nxt[r] = (pt_r[r] < lo_r[r]) ? pt_r[r] : lo_r[r];
      hi_nxt[r] = (pt_r[r] > hi_r[r]) ? pt_r[r] : hi_r[r];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PROD_W'(rot_r[r][c]) * PROD_W'(vtx[c]);
        end
        // translation travels with the vertex so later pose writes cannot touch it
        s1_t_r[r] <= trn_r[r];
        rnd_r[r]  <= sum[r][SUM_W-1:FRAC_DROP];
        s2_t_r[r] <= s1_t_r[r];
        pt_r[r]   <= sat[r];
      end
      s1_last_r <= head.last;
      s2_last_r <= s1_last_r;
      s3_last_r <= s2_last_r;
      if (s3_valid_r && s3_last_r) begin
        out_data_r.min_x <= OUT_W'(lo_nxt[0]);
        out_data_r.min_y <= OUT_W'(lo_nxt[1]);
        out_data_r.min_z <= OUT_W'(lo_nxt[2]);
        out_data_r.max_x <= OUT_W'(hi_nxt[0]);
        out_data_r.max_y <= OUT_W'(hi_nxt[1]);
        out_data_r.max_z <= OUT_W'(hi_nxt[2]);
      end
    end
  end

  // control and bound state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        lo_r[r] <= C_HI;
        hi_r[r] <= C_LO;
      end
    end else if (adv) begin
      s1_valid_r  <= pop_vtx;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r && s3_last_r;
      if (s3_valid_r) begin
        for (int r = 0; r < 3; r++) begin
          lo_r[r] <= s3_last_r ? C_HI : lo_nxt[r];
          hi_r[r] <= s3_last_r ? C_LO : hi_nxt[r];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
